/* rtl/utrd_pkg.sv */
`timescale 1ns / 1ps

package utrd_pkg;

  localparam int StoreDepth = 32;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int CountW     = StoreAw + 1;

  localparam logic [7:0]  ZeroChar      = 8'h30;
  localparam logic [4:0]  RadixReset    = 5'd10;
  localparam logic [4:0]  RadixMin      = 5'd2;
  localparam logic [4:0]  RadixMax      = 5'd16;
  localparam logic [63:0] AlphaLowReset  = 64'd3978425819141910832;
  localparam logic [63:0] AlphaHighReset = 64'd7378413942531504440;

  typedef enum logic [1:0] {
    RegRadix     = 2'd0,
    RegAlphaLow  = 2'd1,
    RegAlphaHigh = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRead,
    StEmit
  } state_t;

  // Out-of-range radix codes clamp to the nearest legal base.
  function automatic logic [4:0] eff_radix(input logic [4:0] r);
    logic [4:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  function automatic logic [7:0] glyph(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [3:0] d);
    logic [63:0] word;
    word = d[3] ? hi : lo;
    return word[{d[2:0], 3'b000} +: 8];
  endfunction

endpackage

/* rtl/unsigned_to_radix_digits.sv */
`timescale 1ns / 1ps

// Converts an unsigned value to a string of digit characters in a
// programmable radix (2..16), most significant digit first, no leading zeros.
// Input channel: value / value_valid / value_stall. Output channel:
// digit_char, last / digit_valid / digit_stall; last marks the final
// character of a value. A zero value yields the single character '0'.
// Config channel: cfg_index selects radix, alphabet_low, alphabet_high;
// cfg_ready is always high. Write config only while the block is idle.
// Digits come from one shared bit-serial divider of W = min(VALUE_WIDTH, 32)
// bits, one division per digit; all digits of a value are divided out first,
// then each character is read from the digit buffer and emitted.
// value_stall stays high for the whole conversion; a new value is taken as
// soon as the last character sits in the output register.
// A stalled output holds its character and the sequencer waits for it.
// Reset (synchronous) returns to idle, drops digit_valid and restores
// radix 10 and the alphabet "0123456789abcdef".
module unsigned_to_radix_digits #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   value_valid,
  output logic                   value_stall,
  output logic [7:0]             digit_char,
  output logic                   last,
  output logic                   digit_valid,
  input  logic                   digit_stall,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data
);
  import utrd_pkg::*;

  localparam int UsedW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  state_t state, state_next;

  logic [4:0]         radix;
  logic [63:0]        alphabet_low;
  logic [63:0]        alphabet_high;
  logic [CountW-1:0]  count, count_next;
  logic [StoreAw-1:0] rd_idx, rd_idx_next;
  logic               zero_flag, zero_flag_next;

  logic [UsedW-1:0]   in_val;
  logic               accept;
  logic               div_start;
  logic [UsedW-1:0]   div_dividend;
  logic               div_done;
  logic [UsedW-1:0]   div_quo;
  logic [3:0]         div_rem;
  logic               mem_we;
  logic [3:0]         mem_rdata;
  logic               out_load;
  logic               out_last;

  assign cfg_ready   = 1'b1;
  assign in_val      = value[UsedW-1:0];
  assign value_stall = (state != StIdle);
  assign accept      = value_valid && !value_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= RadixReset;
      alphabet_low  <= AlphaLowReset;
      alphabet_high <= AlphaHighReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegRadix:     radix         <= cfg_data[4:0];
        RegAlphaLow:  alphabet_low  <= cfg_data;
        RegAlphaHigh: alphabet_high <= cfg_data;
        default:      ;
      endcase
    end
  end

  utrd_divider #(.WIDTH(UsedW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_radix(radix)),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  utrd_digit_buf u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[StoreAw-1:0]),
    .wdata (div_rem),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      count     <= '0;
      rd_idx    <= '0;
      zero_flag <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_idx    <= rd_idx_next;
      zero_flag <= zero_flag_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_idx_next    = rd_idx;
    zero_flag_next = zero_flag;
    div_start      = 1'b0;
    div_dividend   = in_val;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    out_last       = (rd_idx == '0);
    unique case (state)
      StIdle: begin
        if (accept) begin
          if (in_val == '0) begin
            zero_flag_next = 1'b1;
            count_next     = CountW'(1);
            rd_idx_next    = '0;
            state_next     = StEmit;
          end else begin
            zero_flag_next = 1'b0;
            count_next     = '0;
            div_start      = 1'b1;
            state_next     = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          mem_we     = 1'b1;
          count_next = count + 1'b1;
          if (div_quo == '0 || count == CountW'(StoreDepth - 1)) begin
            rd_idx_next = count[StoreAw-1:0];
            state_next  = StRead;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quo;
          end
        end
      end
      StRead: begin
        state_next = StEmit;
      end
      StEmit: begin
        if (!digit_valid || !digit_stall) begin
          out_load = 1'b1;
          if (out_last) begin
            state_next = StIdle;
          end else begin
            rd_idx_next = rd_idx - 1'b1;
            state_next  = StRead;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (out_load) begin
      digit_valid <= 1'b1;
    end else if (!digit_stall) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digit_char <= zero_flag ? ZeroChar : glyph(alphabet_low, alphabet_high, mem_rdata);
      last       <= out_last;
    end
  end

endmodule

/* rtl/utrd_divider.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor is at most 16,
// so the partial remainder fits in 4 bits.
module utrd_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [4:0]       divisor,
  output logic             done,
  output logic [WIDTH-1:0] quo,
  output logic [3:0]       rem
);
  import utrd_pkg::*;

  localparam int CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [4:0]      trial;
  logic            ge;
  logic [4:0]      diff;

  assign trial = {rem, quo[WIDTH-1]};
  assign ge    = (trial >= divisor);
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntLast) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[WIDTH-2:0], ge};
      rem <= ge ? diff[3:0] : trial[3:0];
    end
  end

endmodule

/* rtl/utrd_digit_buf.sv */
`timescale 1ns / 1ps

module utrd_digit_buf (
  input  logic                        clk,
  input  logic                        we,
  input  logic [utrd_pkg::StoreAw-1:0] waddr,
  input  logic [3:0]                  wdata,
  input  logic [utrd_pkg::StoreAw-1:0] raddr,
  output logic [3:0]                  rdata
);
  import utrd_pkg::*;

  logic [3:0] mem [StoreDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
